@@ rtl/core/vfc_pkg.sv @@
`timescale 1ns / 1ps

package vfc_pkg;

    // default chunk dimensions
    localparam int SIZE_X_DEF = 16;
    localparam int SIZE_Y_DEF = 16;
    localparam int SIZE_Z_DEF = 16;

    // width of the cell coordinate fields
    localparam int COORD_W = 4;
    // width of the visible face mask
    localparam int MASK_W = 6;

    // input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // face codes, also the bit position in the mask
    localparam logic [2:0] FACE_PX   = 3'd0;
    localparam logic [2:0] FACE_NX   = 3'd1;
    localparam logic [2:0] FACE_PY   = 3'd2;
    localparam logic [2:0] FACE_NY   = 3'd3;
    localparam logic [2:0] FACE_PZ   = 3'd4;
    localparam logic [2:0] FACE_NZ   = 3'd5;
    localparam logic [2:0] FACE_LAST = 3'd6;

endpackage

@@ rtl/core/vfc_ram.sv @@
`timescale 1ns / 1ps

module vfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/voxel_face_visibility_culler.sv @@
`timescale 1ns / 1ps
// write: accepted with no result; the cell is updated at the transfer edge
// query: result valid after six neighbour reads through the
//   single read port of the occupancy memory, whose read data is registered
// a new query waits until the previous result is taken; writes one per cycle while idle
// reset: synchronous active-low; afterwards a clearing pass writes all
//   SIZE_X*SIZE_Y*SIZE_Z cells (4096 by default) empty, with s_ready low throughout
module voxel_face_visibility_culler #(
    parameter int SIZE_X = vfc_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = vfc_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = vfc_pkg::SIZE_Z_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [vfc_pkg::COORD_W-1:0] s_cell_x,
    input  logic [vfc_pkg::COORD_W-1:0] s_cell_y,
    input  logic [vfc_pkg::COORD_W-1:0] s_cell_z,
    input  logic                        s_solid,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vfc_pkg::MASK_W-1:0]  m_visible_mask
);

    localparam int CELL_COUNT = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int NW         = vfc_pkg::COORD_W + 1;

    localparam logic [AW-1:0] STRIDE_Y   = AW'(SIZE_X);
    localparam logic [AW-1:0] STRIDE_Z   = AW'(SIZE_X * SIZE_Y);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_QUERY  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0] face_reg, face_next;
    logic outside_reg, outside_next;
    logic [vfc_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic [vfc_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;

    logic s_xfer;
    logic wr_inside;
    logic ram_we, ram_wdata, ram_re, ram_rdata;
    logic [AW-1:0] ram_waddr, wr_addr, rd_addr;
    logic [NW-1:0] nx, ny, nz;
    logic under;
    logic outside;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_RESULT);
    assign m_visible_mask = mask_reg;
    assign s_xfer         = s_valid && s_ready;

    // write address and range check from the input ports
    assign wr_inside = (32'(s_cell_x) < SIZE_X) && (32'(s_cell_y) < SIZE_Y)
                    && (32'(s_cell_z) < SIZE_Z);
    assign wr_addr   = AW'(s_cell_x) + AW'(s_cell_y) * STRIDE_Y + AW'(s_cell_z) * STRIDE_Z;

    // neighbour coordinate of the face being read
    always_comb begin
        nx    = {1'b0, x_reg};
        ny    = {1'b0, y_reg};
        nz    = {1'b0, z_reg};
        under = 1'b0;
        unique case (face_reg)
            vfc_pkg::FACE_PX: begin
                nx = {1'b0, x_reg} + NW'(1);
            end
            vfc_pkg::FACE_NX: begin
                nx    = {1'b0, x_reg} - NW'(1);
                under = (x_reg == '0);
            end
            vfc_pkg::FACE_PY: begin
                ny = {1'b0, y_reg} + NW'(1);
            end
            vfc_pkg::FACE_NY: begin
                ny    = {1'b0, y_reg} - NW'(1);
                under = (y_reg == '0);
            end
            vfc_pkg::FACE_PZ: begin
                nz = {1'b0, z_reg} + NW'(1);
            end
            vfc_pkg::FACE_NZ: begin
                nz    = {1'b0, z_reg} - NW'(1);
                under = (z_reg == '0);
            end
            default: begin
                under = 1'b1;
            end
        endcase
        outside = under || (32'(nx) >= SIZE_X) || (32'(ny) >= SIZE_Y)
               || (32'(nz) >= SIZE_Z);
    end

    assign rd_addr = AW'(nx) + AW'(ny) * STRIDE_Y + AW'(nz) * STRIDE_Z;
    assign ram_re  = (state_reg == ST_QUERY) && (face_reg != vfc_pkg::FACE_LAST);

    // memory write: clearing pass or a write transfer
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr;
        ram_wdata = s_solid;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 1'b0;
        end else if (s_xfer && (s_op == vfc_pkg::OP_WRITE) && wr_inside) begin
            ram_we = 1'b1;
        end
    end

    vfc_ram #(
        .WIDTH (1),
        .DEPTH (CELL_COUNT)
    ) u_occ_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        face_next    = face_reg;
        outside_next = outside_reg;
        mask_next    = mask_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer && (s_op == vfc_pkg::OP_QUERY)) begin
                    state_next = ST_QUERY;
                    face_next  = vfc_pkg::FACE_PX;
                end
            end
            ST_QUERY: begin
                outside_next = outside;
                face_next    = face_reg + 3'd1;
                // read data of the previous face arrives now; shift it in
                if (face_reg != vfc_pkg::FACE_PX) begin
                    mask_next = {outside_reg | ~ram_rdata, mask_reg[vfc_pkg::MASK_W-1:1]};
                end
                if (face_reg == vfc_pkg::FACE_LAST) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            face_reg  <= vfc_pkg::FACE_PX;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            face_reg  <= face_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        outside_reg <= outside_next;
        mask_reg    <= mask_next;
        if (s_xfer) begin
            x_reg <= s_cell_x;
            y_reg <= s_cell_y;
            z_reg <= s_cell_z;
        end
    end

    // checks
    a_ready_result_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_query_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (s_op == vfc_pkg::OP_QUERY)) |=> (!m_valid && (state_reg == ST_QUERY)))
        else $error("query transfer did not start the read sequence");

    a_write_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_IDLE)))
        else $error("occupancy written during a query");

    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QUERY) |-> (face_reg <= vfc_pkg::FACE_LAST))
        else $error("face counter out of range");

    a_result_after_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(face_reg == vfc_pkg::FACE_LAST))
        else $error("result raised before all six faces were read");

endmodule
